// ----- sv/gcr_pkg.sv -----
// gcr_pkg: shared constants, types and the cordic arctangent table
// for the geocentric radius pipeline; no dependencies
package gcr_pkg;

	localparam int CORDIC_STAGES_DEF = 32;
	localparam int ANGLE_BITS_DEF    = 32;

	localparam int RAD_W  = 33;   // radius and equatorial radius width
	localparam int FLAT_W = 32;   // flattening width, q0.32
	localparam int ANG_W  = 32;   // latitude width
	localparam int XY_W   = 34;   // cordic x and y width, q.30 plus growth
	localparam int K_W    = 63;   // k^2 and k^4 in q.62
	localparam int SQ_W   = 61;   // c^2 and s^2 in q.60

	localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [RAD_W-1:0] RADIUS_MAX = 33'h1_FFFF_FFFF;
	localparam logic [RAD_W-1:0] A_RESET    = 33'd6378137000;
	localparam logic [FLAT_W-1:0] F_RESET   = 32'd14400212;

	typedef enum logic [0:0] {
		REG_EQ_RADIUS  = 1'b0,
		REG_FLATTENING = 1'b1
	} cfg_reg_t;

	// sequencer for the k^2 and k^4 coefficients
	typedef enum logic [2:0] {
		K_IDLE,
		K_SQR,
		K_P0,
		K_P1,
		K_P2,
		K_P3,
		K_FIN
	} kseq_t;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// arctangent of 2^-i scaled to the angle accumulator width
	function automatic logic [63:0] atan_ent(input int i, input int ab);
		logic [63:0] e;
		e = (i < 32) ? {32'd0, ATAN_TAB[i]} : 64'd0;
		if (ab >= 32)
			return e << (ab - 32);
		else
			return (e + (64'd1 << (31 - ab))) >> (32 - ab);
	endfunction

endpackage

// ----- sv/gcr_mulq.sv -----
// gcr_mulq: two-stage product (k * sq + 2^59) >> 60 of a q.62 coefficient
// and a q.60 square, built from 32-bit partial products; uses gcr_pkg
module gcr_mulq (
	input  logic                     clk,
	input  logic                     en,
	input  logic [gcr_pkg::K_W-1:0]  k,
	input  logic [gcr_pkg::SQ_W-1:0] sq,
	output logic [gcr_pkg::K_W-1:0]  prod
);

	logic [63:0] pll_s1;
	logic [60:0] plh_s1;
	logic [62:0] phl_s1;
	logic [59:0] phh_s1;
	logic [123:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= {32'd0, k[31:0]} * {32'd0, sq[31:0]};
			plh_s1 <= {29'd0, k[31:0]} * {32'd0, sq[60:32]};
			phl_s1 <= {32'd0, k[62:32]} * {31'd0, sq[31:0]};
			phh_s1 <= {29'd0, k[62:32]} * {31'd0, sq[60:32]};
		end
	end

	always_comb begin
		sum = {60'd0, pll_s1}
			+ ({63'd0, plh_s1} << 32)
			+ ({61'd0, phl_s1} << 32)
			+ ({64'd0, phh_s1} << 64)
			+ (124'd1 << 59);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= sum[122:60];
		end
	end

endmodule

// ----- sv/geocentric_radius_at_latitude.sv -----
// geocentric_radius_at_latitude: ellipsoid radius at a latitude, fully pipelined
// depends on gcr_pkg and gcr_mulq
//
//  channel | signals                                  | beat carries
//  --------+------------------------------------------+--------------------------
//  in      | in_valid, in_ready, latitude_angle       | one latitude, 2^31 = pi
//  out     | out_valid, out_ready, radius_mm          | one radius in mm
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register index and value
//
// one beat enters per cycle while in_ready is high; each beat passes through
// fold, cordic, squares, coefficient products, 63-step divider, 64-step
// root, final multiply and rounding before out_valid rises
// after reset and after each flattening write a sequencer rebuilds k^2 from
// a 33x33 square and k^4 with one shared 32x32 multiplier; in_ready is low meanwhile
// a stall on out freezes every stage at once; nothing moves, nothing is dropped
module geocentric_radius_at_latitude #(
	parameter int CORDIC_STAGES = gcr_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS    = gcr_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [gcr_pkg::ANG_W-1:0] latitude_angle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gcr_pkg::RAD_W-1:0]        radius_mm,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [0:0]                       cfg_index,
	input  logic [gcr_pkg::RAD_W-1:0]        cfg_data
);

	localparam int ZW     = ANGLE_BITS + 2;          // angle accumulator with headroom
	localparam int XW     = gcr_pkg::XY_W;
	localparam int DIVN   = 63;                      // quotient bits
	localparam int SQN    = 64;                      // root bits
	localparam int LAT    = CORDIC_STAGES + 136;
	localparam int ZF_LEN = DIVN + SQN + 2;          // den-zero flag delay line
	localparam int SH_UP  = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
	localparam int SH_DN  = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
	localparam int ANG_W_L = gcr_pkg::ANG_W;

	// configuration registers
	logic [gcr_pkg::RAD_W-1:0]  a_q;
	logic [gcr_pkg::FLAT_W-1:0] flat_q;
	logic                       cfg_fire;

	// coefficient sequencer
	gcr_pkg::kseq_t   kst_q, kst_d;
	logic [gcr_pkg::K_W-1:0] k2_q, k4_q;
	logic [125:0]     kacc_q;
	logic [32:0]      m;
	logic [65:0]      msq;
	logic [31:0]      mop_a, mop_b;
	logic [63:0]      mprod;
	logic [125:0]     mterm;
	logic             busy;

	// pipeline control
	logic             en;
	logic             in_fire;
	logic [LAT-1:0]   vld_q;

	// fold and cordic
	logic signed [ZW-1:0] z_s [CORDIC_STAGES+1];
	logic signed [XW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [XW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_n [CORDIC_STAGES];
	logic signed [XW-1:0] x_n [CORDIC_STAGES];
	logic signed [XW-1:0] y_n [CORDIC_STAGES];
	logic signed [ANG_W_L-1:0] th_f;
	logic signed [63:0]   th64;
	logic signed [63:0]   z0;

	// squares
	logic [XW-1:0]   ax, ay;
	logic [30:0]     c_s1, s_s1;
	logic [gcr_pkg::SQ_W-1:0] cc_s2, ss_s2, cc_s3, cc_s4;
	logic [gcr_pkg::K_W-1:0]  t2_s4, t4_s4;
	logic [63:0]     den_c, num_c;

	// divider
	logic [64:0] rem_d [DIVN+1];
	logic [62:0] q_d   [DIVN+1];
	logic [63:0] den_d [DIVN+1];
	logic [64:0] rem_n [DIVN];
	logic [62:0] q_n   [DIVN];
	logic [ZF_LEN-1:0] zf_s;

	// square root
	logic [62:0] qc;
	logic [63:0] rt_s [SQN+1];
	logic [66:0] sr_s [SQN+1];
	logic [62:0] sq_s [SQN+1];
	logic [63:0] rt_n [SQN];
	logic [66:0] sr_n [SQN];

	// final scale
	logic [64:0] p0_s7, p1_s7;
	logic        zf_s7;
	logic [97:0] pfin;
	logic [35:0] rfin;
	logic [gcr_pkg::RAD_W-1:0] radius_s8;

	// ---------------------------------------------------------------
	// configuration port, always ready
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= gcr_pkg::A_RESET;
			flat_q <= gcr_pkg::F_RESET;
		end else if (cfg_fire) begin
			unique case (gcr_pkg::cfg_reg_t'(cfg_index))
				gcr_pkg::REG_EQ_RADIUS:  a_q    <= cfg_data;
				gcr_pkg::REG_FLATTENING: flat_q <= cfg_data[gcr_pkg::FLAT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// k = 1 - f; k^2 = (m^2 + 2) >> 2 with m = 2^32 - f
	// k^4 = (k^2 * k^2 + 2^61) >> 62 over four partial products
	// ---------------------------------------------------------------
	assign m     = 33'h1_0000_0000 - {1'b0, flat_q};
	assign msq   = {33'd0, m} * {33'd0, m};
	assign mprod = {32'd0, mop_a} * {32'd0, mop_b};
	assign busy  = (kst_q != gcr_pkg::K_IDLE);

	always_comb begin
		kst_d = kst_q;
		mop_a = 32'd0;
		mop_b = 32'd0;
		mterm = 126'd0;
		unique case (kst_q)
			gcr_pkg::K_IDLE: kst_d = gcr_pkg::K_IDLE;
			gcr_pkg::K_SQR:  kst_d = gcr_pkg::K_P0;
			gcr_pkg::K_P0: begin
				mop_a = k2_q[31:0];
				mop_b = k2_q[31:0];
				mterm = {62'd0, mprod};
				kst_d = gcr_pkg::K_P1;
			end
			gcr_pkg::K_P1: begin
				mop_a = k2_q[31:0];
				mop_b = {1'b0, k2_q[62:32]};
				mterm = {62'd0, mprod} << 32;
				kst_d = gcr_pkg::K_P2;
			end
			gcr_pkg::K_P2: begin
				mop_a = {1'b0, k2_q[62:32]};
				mop_b = k2_q[31:0];
				mterm = {62'd0, mprod} << 32;
				kst_d = gcr_pkg::K_P3;
			end
			gcr_pkg::K_P3: begin
				mop_a = {1'b0, k2_q[62:32]};
				mop_b = {1'b0, k2_q[62:32]};
				mterm = {62'd0, mprod} << 64;
				kst_d = gcr_pkg::K_FIN;
			end
			gcr_pkg::K_FIN:  kst_d = gcr_pkg::K_IDLE;
			default:         kst_d = gcr_pkg::K_SQR;
		endcase
		// a new flattening restarts the rebuild
		if (cfg_fire && gcr_pkg::cfg_reg_t'(cfg_index) == gcr_pkg::REG_FLATTENING)
			kst_d = gcr_pkg::K_SQR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kst_q <= gcr_pkg::K_SQR;
		else
			kst_q <= kst_d;
	end

	always_ff @(posedge clk) begin
		if (kst_q == gcr_pkg::K_SQR) begin
			k2_q   <= 63'((67'(msq) + 67'd2) >> 2);
			kacc_q <= 126'd0;
		end else if (kst_q == gcr_pkg::K_FIN) begin
			k4_q   <= 63'((kacc_q + (126'd1 << 61)) >> 62);
		end else if (kst_q != gcr_pkg::K_IDLE) begin
			kacc_q <= kacc_q + mterm;
		end
	end

	// ---------------------------------------------------------------
	// pipeline enable: everything advances unless the output is held
	// ---------------------------------------------------------------
	assign en        = !out_valid || out_ready;
	assign in_ready  = en && !busy;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = vld_q[LAT-1];
	assign radius_mm = radius_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_fire};
	end

	// ---------------------------------------------------------------
	// fold by pi (only squares of c and s are used) and scale the angle
	// folding into [-2^30, 2^30) is a sign extension of bit 30
	// ---------------------------------------------------------------
	always_comb begin
		th_f = {latitude_angle[30], latitude_angle[30:0]};
		th64 = 64'(th_f);
		z0   = (th64 <<< SH_UP) >>> SH_DN;
	end

	// rotation-mode cordic, one stage per micro-rotation
	always_comb begin
		logic [63:0] ent;
		logic signed [ZW-1:0] e;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			ent = gcr_pkg::atan_ent(i, ANGLE_BITS);
			e   = ent[ZW-1:0];
			if (!z_s[i][ZW-1]) begin
				x_n[i] = x_s[i] - (y_s[i] >>> i);
				y_n[i] = y_s[i] + (x_s[i] >>> i);
				z_n[i] = z_s[i] - e;
			end else begin
				x_n[i] = x_s[i] + (y_s[i] >>> i);
				y_n[i] = y_s[i] - (x_s[i] >>> i);
				z_n[i] = z_s[i] + e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= z0[ZW-1:0];
			x_s[0] <= gcr_pkg::CORDIC_X0;
			y_s[0] <= '0;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				x_s[i+1] <= x_n[i];
				y_s[i+1] <= y_n[i];
				z_s[i+1] <= z_n[i];
			end
		end
	end

	// ---------------------------------------------------------------
	// |c|, |s| clamped to 1.0, then squared in q.60
	// ---------------------------------------------------------------
	always_comb begin
		ax = x_s[CORDIC_STAGES][XW-1] ? XW'(-x_s[CORDIC_STAGES]) : XW'(x_s[CORDIC_STAGES]);
		ay = y_s[CORDIC_STAGES][XW-1] ? XW'(-y_s[CORDIC_STAGES]) : XW'(y_s[CORDIC_STAGES]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= (ax > (XW'(1) << 30)) ? (31'd1 << 30) : ax[30:0];
			s_s1  <= (ay > (XW'(1) << 30)) ? (31'd1 << 30) : ay[30:0];
			cc_s2 <= {30'd0, c_s1} * {30'd0, c_s1};
			ss_s2 <= {30'd0, s_s1} * {30'd0, s_s1};
			cc_s3 <= cc_s2;
			cc_s4 <= cc_s3;
		end
	end

	// k^2 s^2 and k^4 s^2, rounded to q.62
	gcr_mulq u_mul_k2 (
		.clk  (clk),
		.en   (en),
		.k    (k2_q),
		.sq   (ss_s2),
		.prod (t2_s4)
	);

	gcr_mulq u_mul_k4 (
		.clk  (clk),
		.en   (en),
		.k    (k4_q),
		.sq   (ss_s2),
		.prod (t4_s4)
	);

	// denominator c^2 + k^2 s^2, numerator c^2 + k^4 s^2
	always_comb begin
		den_c = {1'b0, cc_s4, 2'b00} + {1'b0, t2_s4};
		num_c = {1'b0, cc_s4, 2'b00} + {1'b0, t4_s4};
	end

	// ---------------------------------------------------------------
	// restoring divider, one quotient bit per stage; first step unshifted
	// ---------------------------------------------------------------
	always_comb begin
		logic [64:0] r;
		for (int j = 0; j < DIVN; j++) begin
			r = (j == 0) ? rem_d[j] : (rem_d[j] << 1);
			if (r >= {1'b0, den_d[j]}) begin
				rem_n[j] = r - {1'b0, den_d[j]};
				q_n[j]   = {q_d[j][61:0], 1'b1};
			end else begin
				rem_n[j] = r;
				q_n[j]   = {q_d[j][61:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0] <= {1'b0, num_c};
			den_d[0] <= den_c;
			q_d[0]   <= '0;
			for (int j = 0; j < DIVN; j++) begin
				rem_d[j+1] <= rem_n[j];
				den_d[j+1] <= den_d[j];
				q_d[j+1]   <= q_n[j];
			end
			zf_s <= {zf_s[ZF_LEN-2:0], (den_c == 64'd0)};
		end
	end

	// ---------------------------------------------------------------
	// quotient clamped to 1.0, then digit-by-digit root of q * 2^62
	// ---------------------------------------------------------------
	assign qc = (q_d[DIVN] > (63'd1 << 62)) ? (63'd1 << 62) : q_d[DIVN];

	always_comb begin
		logic [127:0] rad;
		logic [66:0]  rw;
		logic [66:0]  tr;
		for (int j = 0; j < SQN; j++) begin
			rad = {3'b000, sq_s[j], 62'd0};
			rw  = {sr_s[j][64:0], rad[2*(SQN-1-j) +: 2]};
			tr  = {1'b0, rt_s[j], 2'b01};
			if (rw >= tr) begin
				sr_n[j] = rw - tr;
				rt_n[j] = {rt_s[j][62:0], 1'b1};
			end else begin
				sr_n[j] = rw;
				rt_n[j] = {rt_s[j][62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0] <= qc;
			rt_s[0] <= '0;
			sr_s[0] <= '0;
			for (int j = 0; j < SQN; j++) begin
				sq_s[j+1] <= sq_s[j];
				rt_s[j+1] <= rt_n[j];
				sr_s[j+1] <= sr_n[j];
			end
		end
	end

	// ---------------------------------------------------------------
	// r = (a * t + 2^61) >> 62, split in two 33x32 products
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s7 <= {32'd0, a_q} * {33'd0, rt_s[SQN][31:0]};
			p1_s7 <= {32'd0, a_q} * {33'd0, rt_s[SQN][63:32]};
			zf_s7 <= zf_s[ZF_LEN-1];
		end
	end

	always_comb begin
		pfin = {33'd0, p0_s7} + ({33'd0, p1_s7} << 32) + (98'd1 << 61);
		rfin = pfin[97:62];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf_s7)
				radius_s8 <= '0;
			else if (rfin > {3'b000, gcr_pkg::RADIUS_MAX})
				radius_s8 <= gcr_pkg::RADIUS_MAX;
			else
				radius_s8 <= rfin[gcr_pkg::RAD_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// k^2 never exceeds 1.0 once built
	a_k2_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> k2_q <= (63'd1 << 62))
		else $error("k^2 above one");

	// k^4 is never larger than k^2 when a rebuild completes
	a_k4_le_k2: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> k4_q <= k2_q)
		else $error("k^4 above k^2");

	// the geocentric radius never exceeds the equatorial radius
	a_r_le_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> radius_mm <= a_q)
		else $error("radius above equatorial radius");

	// no beat is taken when a coefficient rebuild starts
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> !vld_q[0])
		else $error("beat accepted during coefficient rebuild");

endmodule
